>>> design/irlf_pkg.sv
// Shared types, constants and helper function of the TCP ingress rate limit filter.
package irlf_pkg;

   // Per-source state table size and the index width that follows from it.
   localparam int SOURCE_SLOTS = 1024;
   localparam int SLOT_W       = $clog2(SOURCE_SLOTS);

   // Field widths of the header, the registers and the stored state.
   localparam int TIME_W     = 64;
   localparam int PORT_W     = 16;
   localparam int WIN_W      = 36;
   localparam int RATE_W     = 16;
   localparam int TOKEN_W    = 16;
   localparam int SYN_CNT_W  = 8;
   localparam int GCNT_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 36;

   // Header match values.
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [3:0]  IHL_MIN_WORDS  = 4'd5;

   // One second in nanoseconds; the refill span is capped here.
   localparam int              ELAPSED_W  = 30;
   localparam logic [ELAPSED_W-1:0] NS_PER_SEC = 30'd1000000000;

   // Refill quotient floor(elapsed * rate / 1e9). The divisor is split into
   // 2^9 times an odd factor. The odd factor is handled by a reciprocal
   // multiply on the top bits of the product and a single correction step.
   localparam int PROD_W      = ELAPSED_W + RATE_W;
   localparam int POW2_SHIFT  = 9;
   localparam int PD_W        = PROD_W - POW2_SHIFT;
   localparam int EST_SHIFT   = 13;
   localparam int PH_W        = PD_W - EST_SHIFT;
   localparam int RECIP_W     = 32;
   localparam int RECIP_SHIFT = 39;
   localparam int EST_PROD_W  = PH_W + RECIP_W;
   localparam logic [20:0] DIV_ODD = 21'(1000000000 / (1 << POW2_SHIFT));
   localparam logic [63:0] RECIP_WIDE =
      (64'd1 << (RECIP_SHIFT + EST_SHIFT)) / 64'(DIV_ODD);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];

   // Result reason codes.
   typedef enum logic [2:0] {
      RSN_NOT_TARGET = 3'd0,
      RSN_PASS       = 3'd1,
      RSN_ALLOW      = 3'd2,
      RSN_BLOCK      = 3'd3,
      RSN_SRC_SYN    = 3'd4,
      RSN_GLB_SYN    = 3'd5,
      RSN_TOKENS     = 3'd6
   } reason_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INGRESS_PORT     = 3'd0,
      CSR_SYN_LIMIT        = 3'd1,
      CSR_GLOBAL_SYN_LIMIT = 3'd2,
      CSR_WINDOW_LENGTH    = 3'd3,
      CSR_TOKEN_RATE       = 3'd4,
      CSR_TOKEN_BURST      = 3'd5
   } csr_idx_type;

   // Configuration register set.
   typedef struct packed {
      logic [PORT_W-1:0]    ingress_port;
      logic [SYN_CNT_W-1:0] syn_limit;
      logic [GCNT_W-1:0]    global_syn_limit;
      logic [WIN_W-1:0]     window_length_ns;
      logic [RATE_W-1:0]    token_rate;
      logic [TOKEN_W-1:0]   token_burst;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      ingress_port:     16'd8180,
      syn_limit:        8'd64,
      global_syn_limit: 16'd6250,
      window_length_ns: 36'd1000000000,
      token_rate:       16'd2000,
      token_burst:      16'd2000
   };

   // A drop verdict follows from the reason code.
   function automatic logic verdict_of(input reason_type rsn);
      logic drop;
      case (rsn) inside
         RSN_BLOCK, RSN_SRC_SYN, RSN_GLB_SYN, RSN_TOKENS: drop = 1'b1;
         default: drop = 1'b0;
      endcase
      return drop;
   endfunction

endpackage

>>> design/irlf_if.sv
// Channel interfaces of the TCP ingress rate limit filter: headers, verdicts, register writes.

// Parsed packet header channel.
interface irlf_req_if import irlf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              frame_complete;
   logic [15:0]       ethertype;
   logic [7:0]        ip_protocol;
   logic [3:0]        ip_header_words;
   logic [PORT_W-1:0] destination_port;
   logic              syn_flag;
   logic              ack_flag;
   logic              allowlist_hit;
   logic              blocklist_hit;
   logic [9:0]        source_slot;
   logic [TIME_W-1:0] time_ns;

   modport source (
      output valid, frame_complete, ethertype, ip_protocol, ip_header_words,
      output destination_port, syn_flag, ack_flag, allowlist_hit, blocklist_hit,
      output source_slot, time_ns,
      input  ready
   );
   modport sink (
      input  valid, frame_complete, ethertype, ip_protocol, ip_header_words,
      input  destination_port, syn_flag, ack_flag, allowlist_hit, blocklist_hit,
      input  source_slot, time_ns,
      output ready
   );
endinterface

// Verdict channel.
interface irlf_rsp_if import irlf_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       verdict;
   logic [2:0] reason;

   modport source (output valid, verdict, reason, input ready);
   modport sink (input valid, verdict, reason, output ready);
endinterface

// Register write channel.
interface irlf_csr_if import irlf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> design/irlf_csr.sv
// Configuration register file of the TCP ingress rate limit filter.
module irlf_csr import irlf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   irlf_csr_if.sink   csr_bus,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken.
   assign csr_bus.ready = 1'b1;

   // Register decode; indexes beyond the list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_idx_type'(csr_bus.index))
            CSR_INGRESS_PORT:     cfg_in.ingress_port     = csr_bus.data[PORT_W-1:0];
            CSR_SYN_LIMIT:        cfg_in.syn_limit        = csr_bus.data[SYN_CNT_W-1:0];
            CSR_GLOBAL_SYN_LIMIT: cfg_in.global_syn_limit = csr_bus.data[GCNT_W-1:0];
            CSR_WINDOW_LENGTH:    cfg_in.window_length_ns = csr_bus.data[WIN_W-1:0];
            CSR_TOKEN_RATE:       cfg_in.token_rate       = csr_bus.data[RATE_W-1:0];
            CSR_TOKEN_BURST:      cfg_in.token_burst      = csr_bus.data[TOKEN_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/irlf_refill.sv
// Token refill unit: four-stage pipeline computing floor(elapsed * rate / 1e9).
module irlf_refill import irlf_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic [ELAPSED_W-1:0] elapsed,
   input  logic [RATE_W-1:0]    rate,
   output logic [TOKEN_W-1:0]   quot
);

   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [PD_W-1:0]       pd_b_ff, pd_b_in;
   logic [PD_W-1:0]       pd_c_ff;
   logic [EST_PROD_W-1:0] est_prod;
   logic [TOKEN_W-1:0]    est_ff, est_in;
   logic [TOKEN_W-1:0]    est_c_ff;
   logic [PD_W-1:0]       back_ff, back_in;
   logic [PD_W-1:0]       rem;
   logic [TOKEN_W-1:0]    quot_ff, quot_in;

   always_comb begin
      // Stage A: elapsed time times rate.
      prod_in = {{(PROD_W-ELAPSED_W){1'b0}}, elapsed} * {{(PROD_W-RATE_W){1'b0}}, rate};

      // Stage B: drop the power-of-two part of the divisor, then estimate the
      // quotient by the odd part from the top bits with a reciprocal multiply.
      // The estimate is never high and at most one low.
      pd_b_in  = prod_ff[PROD_W-1:POW2_SHIFT];
      est_prod = {{(EST_PROD_W-PH_W){1'b0}}, prod_ff[PROD_W-1:POW2_SHIFT+EST_SHIFT]} *
                 {{(EST_PROD_W-RECIP_W){1'b0}}, RECIP};
      est_in   = est_prod[RECIP_SHIFT+TOKEN_W-1:RECIP_SHIFT];

      // Stage C: multiply the estimate back by the odd divisor.
      back_in = {{(PD_W-TOKEN_W){1'b0}}, est_ff} * {{(PD_W-21){1'b0}}, DIV_ODD};

      // Stage D: correct the estimate when the remainder still holds a divisor.
      rem     = pd_c_ff - back_ff;
      quot_in = est_c_ff + TOKEN_W'(rem >= PD_W'(DIV_ODD));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         pd_b_ff  <= pd_b_in;
         est_ff   <= est_in;
         pd_c_ff  <= pd_b_ff;
         est_c_ff <= est_ff;
         back_ff  <= back_in;
         quot_ff  <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

>>> design/tcp_ingress_rate_limit_filter_top.sv
// Top level of the TCP ingress rate limit filter: header pipeline, per-source tables, verdicts.
//
// The filter takes one parsed header per clock while neither the interlock, the
// table clearing nor a stalled verdict holds it, and returns one verdict per
// header, in order. Headers that use different source slots flow at one per
// cycle while the verdict channel does not stall. A target header whose source
// slot matches a target still in the six pipeline stages waits in the input
// register until that one has written its slot back, so headers from one source
// do not overlap in the pipeline; the read-modify-write of the per-source SYN
// window and token bucket tables sets that limit. A stalled verdict stalls the
// whole pipeline. After reset the filter sweeps both 1024-entry source tables to
// clear their valid bits, one entry per cycle, and accepts no header until the
// sweep ends; register writes are taken at any time, one per cycle.
module tcp_ingress_rate_limit_filter_top import irlf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   irlf_req_if.sink    req_bus,
   irlf_rsp_if.source  rsp_bus,
   irlf_csr_if.sink    csr_bus
);

   localparam int LAST_STG = 6;

   // One header as it travels down the pipeline.
   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic               mem_use;
      logic               pure_syn;
      logic               settled;
      reason_type         reason;
      logic [TIME_W-1:0]  now;
      logic               bkt_valid;
      logic [TOKEN_W-1:0] bkt_tokens;
   } item_type;

   // Per-source SYN window entry.
   typedef struct packed {
      logic                 valid;
      logic [TIME_W-1:0]    start;
      logic [SYN_CNT_W-1:0] count;
   } syn_word_type;

   // Per-source token bucket entry.
   typedef struct packed {
      logic               valid;
      logic [TIME_W-1:0]  last;
      logic [TOKEN_W-1:0] tokens;
   } bkt_word_type;

   cfg_type cfg;

   logic              adv;
   logic              hazard;
   logic              move0;
   logic              req_fire;
   logic              is_target;

   item_type          ent_ff, ent_in;
   logic              ent_valid_ff, ent_valid_in;

   item_type          stg_ff [1:LAST_STG];
   item_type          stg_in [1:LAST_STG];
   logic [LAST_STG:1] s_vld_ff, s_vld_in;

   syn_word_type      syn_mem [SOURCE_SLOTS];
   bkt_word_type      bkt_mem [SOURCE_SLOTS];
   syn_word_type      syn_rd_ff;
   bkt_word_type      bkt_rd_ff;

   logic [TIME_W-1:0] g_start_ff, g_start_in;
   logic [GCNT_W-1:0] g_cnt_ff, g_cnt_in;
   logic [TIME_W-1:0] g_elapsed;
   logic              g_open;

   logic [TIME_W-1:0] s_elapsed;
   logic [TIME_W-1:0] b_elapsed;
   logic              s2_syn_open_ff, s2_syn_open_in;
   syn_word_type      s2_syn_word_ff;
   logic [ELAPSED_W-1:0] s2_elapsed_ff, s2_elapsed_in;

   logic              syn_pipe_we;
   syn_word_type      syn_pipe_wd;
   logic              syn_we;
   logic [SLOT_W-1:0] syn_wa;
   syn_word_type      syn_wd;

   logic [TOKEN_W-1:0] refill_q;
   logic [TOKEN_W:0]   tok_sum;
   logic [TOKEN_W-1:0] tok_avail;
   logic               bkt_pipe_we;
   bkt_word_type       bkt_pipe_wd;
   logic               bkt_we;
   logic [SLOT_W-1:0]  bkt_wa;
   bkt_word_type       bkt_wd;

   reason_type        rsp_reason_ff, rsp_reason_in;
   logic              rsp_verdict_ff, rsp_verdict_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              clr_busy_ff, clr_busy_in;
   logic [SLOT_W-1:0] clr_idx_ff, clr_idx_in;

   // Register file.
   irlf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // Token refill arithmetic, aligned so its quotient lands with stage six.
   irlf_refill u_refill (
      .clock   (clock),
      .en      (adv),
      .elapsed (s2_elapsed_ff),
      .rate    (cfg.token_rate),
      .quot    (refill_q)
   );

   // Classify the incoming header: non-targets and list hits settle at once.
   always_comb begin
      is_target = req_bus.frame_complete &&
                  (req_bus.ethertype == ETHERTYPE_IPV4) &&
                  (req_bus.ip_protocol == PROTO_TCP) &&
                  (req_bus.ip_header_words >= IHL_MIN_WORDS) &&
                  (req_bus.destination_port == cfg.ingress_port);
      ent_in            = ent_ff;
      ent_in.slot       = req_bus.source_slot[SLOT_W-1:0];
      ent_in.now        = req_bus.time_ns;
      ent_in.pure_syn   = req_bus.syn_flag && !req_bus.ack_flag;
      ent_in.bkt_valid  = 1'b0;
      ent_in.bkt_tokens = '0;
      ent_in.mem_use    = 1'b0;
      ent_in.settled    = 1'b1;
      if (!is_target) begin
         ent_in.reason = RSN_NOT_TARGET;
      end else if (req_bus.allowlist_hit) begin
         ent_in.reason = RSN_ALLOW;
      end else if (req_bus.blocklist_hit) begin
         ent_in.reason = RSN_BLOCK;
      end else begin
         ent_in.reason  = RSN_PASS;
         ent_in.mem_use = 1'b1;
         ent_in.settled = 1'b0;
      end
   end

   // Pipeline flow control and the same-slot interlock.
   always_comb begin
      adv    = !rsp_valid_ff || rsp_bus.ready;
      hazard = 1'b0;
      for (int k = 1; k <= LAST_STG; k++) begin
         if (s_vld_ff[k] && stg_ff[k].mem_use && (stg_ff[k].slot == ent_ff.slot)) begin
            hazard = 1'b1;
         end
      end
      hazard        = hazard && ent_ff.mem_use;
      move0         = adv && ent_valid_ff && !hazard;
      req_bus.ready = !clr_busy_ff && (!ent_valid_ff || move0);
      req_fire      = req_bus.valid && req_bus.ready;
      if (req_fire) begin
         ent_valid_in = 1'b1;
      end else if (move0) begin
         ent_valid_in = 1'b0;
      end else begin
         ent_valid_in = ent_valid_ff;
      end
      s_vld_in = {s_vld_ff[LAST_STG-1:1], move0};
   end

   // Stage one: global SYN window, source window test and capped refill span.
   always_comb begin
      stg_in[1]            = ent_ff;
      stg_in[2]            = stg_ff[1];
      stg_in[2].bkt_valid  = bkt_rd_ff.valid;
      stg_in[2].bkt_tokens = bkt_rd_ff.tokens;
      g_start_in = g_start_ff;
      g_cnt_in   = g_cnt_ff;
      g_elapsed  = stg_ff[1].now - g_start_ff;
      g_open     = g_elapsed < TIME_W'(cfg.window_length_ns);
      if (s_vld_ff[1] && stg_ff[1].mem_use && stg_ff[1].pure_syn) begin
         if (g_open && (g_cnt_ff >= cfg.global_syn_limit)) begin
            stg_in[2].settled = 1'b1;
            stg_in[2].reason  = RSN_GLB_SYN;
         end else if (g_open) begin
            g_cnt_in = g_cnt_ff + GCNT_W'(1);
         end else begin
            g_start_in = stg_ff[1].now;
            g_cnt_in   = GCNT_W'(1);
         end
      end
      s_elapsed      = stg_ff[1].now - syn_rd_ff.start;
      s2_syn_open_in = syn_rd_ff.valid && (s_elapsed < TIME_W'(cfg.window_length_ns));
      b_elapsed      = stg_ff[1].now - bkt_rd_ff.last;
      if (b_elapsed > TIME_W'(NS_PER_SEC)) begin
         s2_elapsed_in = NS_PER_SEC;
      end else begin
         s2_elapsed_in = b_elapsed[ELAPSED_W-1:0];
      end
   end

   // Stage two: per-source SYN window check and update.
   always_comb begin
      stg_in[3]   = stg_ff[2];
      syn_pipe_we = 1'b0;
      syn_pipe_wd = s2_syn_word_ff;
      if (s_vld_ff[2] && stg_ff[2].mem_use && stg_ff[2].pure_syn && !stg_ff[2].settled) begin
         if (s2_syn_open_ff && (s2_syn_word_ff.count >= cfg.syn_limit)) begin
            stg_in[3].settled = 1'b1;
            stg_in[3].reason  = RSN_SRC_SYN;
         end else begin
            syn_pipe_we       = adv;
            syn_pipe_wd.valid = 1'b1;
            if (s2_syn_open_ff) begin
               syn_pipe_wd.count = s2_syn_word_ff.count + SYN_CNT_W'(1);
            end else begin
               syn_pipe_wd.start = stg_ff[2].now;
               syn_pipe_wd.count = SYN_CNT_W'(1);
            end
         end
      end
   end

   // Stages three to five only carry the header while the refill unit works.
   always_comb begin
      for (int k = 4; k <= LAST_STG; k++) begin
         stg_in[k] = stg_ff[k-1];
      end
   end

   // Stage six: refill, clamp to burst, spend one token.
   always_comb begin
      tok_sum = {1'b0, stg_ff[LAST_STG].bkt_tokens} + {1'b0, refill_q};
      if (!stg_ff[LAST_STG].bkt_valid) begin
         tok_avail = cfg.token_burst;
      end else if (tok_sum > {1'b0, cfg.token_burst}) begin
         tok_avail = cfg.token_burst;
      end else begin
         tok_avail = tok_sum[TOKEN_W-1:0];
      end
      rsp_reason_in      = stg_ff[LAST_STG].reason;
      bkt_pipe_we        = 1'b0;
      bkt_pipe_wd.valid  = 1'b1;
      bkt_pipe_wd.last   = stg_ff[LAST_STG].now;
      bkt_pipe_wd.tokens = tok_avail - TOKEN_W'(1);
      if (s_vld_ff[LAST_STG] && stg_ff[LAST_STG].mem_use && !stg_ff[LAST_STG].settled) begin
         if (tok_avail == '0) begin
            rsp_reason_in = RSN_TOKENS;
         end else begin
            bkt_pipe_we = adv;
         end
      end
      rsp_verdict_in = verdict_of(rsp_reason_in);
      rsp_valid_in   = adv ? s_vld_ff[LAST_STG] : rsp_valid_ff;
   end

   // Table write ports, shared between the clearing sweep and write-back.
   always_comb begin
      clr_idx_in  = clr_idx_ff + SLOT_W'(1);
      clr_busy_in = clr_busy_ff && (clr_idx_ff != SLOT_W'(SOURCE_SLOTS - 1));
      syn_we      = clr_busy_ff || syn_pipe_we;
      syn_wa      = clr_busy_ff ? clr_idx_ff : stg_ff[2].slot;
      syn_wd      = clr_busy_ff ? syn_word_type'('0) : syn_pipe_wd;
      bkt_we      = clr_busy_ff || bkt_pipe_we;
      bkt_wa      = clr_busy_ff ? clr_idx_ff : stg_ff[LAST_STG].slot;
      bkt_wd      = clr_busy_ff ? bkt_word_type'('0) : bkt_pipe_wd;
   end

   // Per-source tables with registered reads issued from the input register.
   always_ff @(posedge clock) begin
      if (syn_we) begin
         syn_mem[syn_wa] <= syn_wd;
      end
      if (adv) begin
         syn_rd_ff <= syn_mem[ent_ff.slot];
      end
   end

   always_ff @(posedge clock) begin
      if (bkt_we) begin
         bkt_mem[bkt_wa] <= bkt_wd;
      end
      if (adv) begin
         bkt_rd_ff <= bkt_mem[ent_ff.slot];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
         s_vld_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         g_start_ff   <= '0;
         g_cnt_ff     <= '0;
         clr_busy_ff  <= 1'b1;
         clr_idx_ff   <= '0;
      end else begin
         ent_valid_ff <= ent_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (adv) begin
            s_vld_ff   <= s_vld_in;
            g_start_ff <= g_start_in;
            g_cnt_ff   <= g_cnt_in;
         end
         if (clr_busy_ff) begin
            clr_idx_ff <= clr_idx_in;
         end
         clr_busy_ff <= clr_busy_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         ent_ff <= ent_in;
      end
      if (adv) begin
         for (int k = 1; k <= LAST_STG; k++) begin
            stg_ff[k] <= stg_in[k];
         end
         s2_syn_open_ff <= s2_syn_open_in;
         s2_syn_word_ff <= syn_rd_ff;
         s2_elapsed_ff  <= s2_elapsed_in;
         rsp_reason_ff  <= rsp_reason_in;
         rsp_verdict_ff <= rsp_verdict_in;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.verdict = rsp_verdict_ff;
   assign rsp_bus.reason  = rsp_reason_ff;

   // Nothing is in flight while the tables are being cleared.
   a_idle_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> (!rsp_valid_ff && (s_vld_ff == '0) && !ent_valid_ff))
      else $error("header in flight during table clearing");

   // The interlock keeps two write-backs of one slot out of the pipeline.
   a_slot_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(syn_pipe_we && bkt_pipe_we && (stg_ff[2].slot == stg_ff[LAST_STG].slot)))
      else $error("two headers of one source slot in the pipeline");

   // The global SYN count only steps by one or restarts its window.
   a_global_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (g_cnt_ff != $past(g_cnt_ff))) |->
         ((g_cnt_ff == GCNT_W'($past(g_cnt_ff) + GCNT_W'(1))) || (g_cnt_ff == GCNT_W'(1))))
      else $error("global SYN count jumped");

   // A new verdict always comes from a header that reached the last stage.
   a_verdict_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(s_vld_ff[LAST_STG]))
      else $error("verdict without a header in the last stage");

endmodule
